/* src/lnwf_pkg.sv */
// lnwf_pkg: shared types and constants of the last negative window finder.
// Holds the stage-1 control word, register indexes and fixed field widths.
// No dependencies.
package lnwf_pkg;

	// fixed widths of the port fields
	localparam int SAMPLE_W  = 16;
	localparam int POS_W     = 7;
	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = CFG_IDX_W'(1);

	// reset value of both dimension registers
	localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(3);

	// column run count saturates here; so does the horizontal count
	localparam logic [1:0] RUN_FULL = 2'd3;

	// control word travelling with an element into the evaluation stage
	typedef struct packed {
		logic valid;     // stage holds an element
		logic neg;       // element is strictly negative
		logic first_row; // row 0: stored run is ignored
		logic first_col; // column 0: horizontal count restarts
		logic row_ge2;   // a window can end in this row
		logic col_ge2;   // a window can end in this column
		logic last;      // final element of the matrix
		logic fwd;       // stored run is still in flight, take forwarded copy
	} lnwf_ctl_t;

endpackage

/* src/lnwf_run_mem.sv */
// lnwf_run_mem: per-column run count store, one write and one read port.
// Read data is registered; read-before-write on a clash.
// No package dependency.
module lnwf_run_mem #(
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [1:0]    rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [1:0]    wr_data
);

	logic [1:0] mem [DEPTH];
	logic [1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port, holds while idle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* src/lnwf_window_eval.sv */
// lnwf_window_eval: second stage. Updates the column run, the horizontal
// count and the hit record, and holds the result word. Uses lnwf_pkg.
module lnwf_window_eval #(
	parameter int IDX_W = 7
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      restart,
	input  logic                      fire,
	input  lnwf_pkg::lnwf_ctl_t       ctl,
	input  logic [IDX_W-1:0]          row,
	input  logic [IDX_W-1:0]          col,
	input  logic [1:0]                rd_data,
	output logic                      wr_en,
	output logic [IDX_W-1:0]          wr_addr,
	output logic [1:0]                wr_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      found,
	output logic [lnwf_pkg::POS_W-1:0] top_row,
	output logic [lnwf_pkg::POS_W-1:0] left_col
);

	import lnwf_pkg::*;

	logic [1:0]       fwd_q;
	logic [1:0]       across_q;
	logic             hit_seen_q;
	logic [IDX_W-1:0] hit_row_q;
	logic [IDX_W-1:0] hit_col_q;
	logic             out_valid_q;
	logic             found_q;
	logic [POS_W-1:0] top_row_q;
	logic [POS_W-1:0] left_col_q;

	logic [1:0]       run_old;
	logic [1:0]       run_new;
	logic [1:0]       across_base;
	logic [1:0]       across_new;
	logic             hit;
	logic             hit_seen_n;
	logic [IDX_W-1:0] hit_row_n;
	logic [IDX_W-1:0] hit_col_n;

	// column run: row 0 starts afresh, back-to-back same column forwards
	always_comb begin
		if (ctl.first_row) begin
			run_old = 2'd0;
		end else if (ctl.fwd) begin
			run_old = fwd_q;
		end else begin
			run_old = rd_data;
		end
		if (!ctl.neg) begin
			run_new = 2'd0;
		end else if (run_old == RUN_FULL) begin
			run_new = RUN_FULL;
		end else begin
			run_new = run_old + 2'd1;
		end
	end

	// horizontal count of full columns, and window match
	always_comb begin
		across_base = ctl.first_col ? 2'd0 : across_q;
		if (run_new != RUN_FULL) begin
			across_new = 2'd0;
		end else if (across_base == RUN_FULL) begin
			across_new = RUN_FULL;
		end else begin
			across_new = across_base + 2'd1;
		end
		hit        = (across_new == RUN_FULL) && ctl.row_ge2 && ctl.col_ge2;
		hit_seen_n = hit_seen_q || hit;
		hit_row_n  = hit ? (row - IDX_W'(2)) : hit_row_q;
		hit_col_n  = hit ? (col - IDX_W'(2)) : hit_col_q;
	end

	assign wr_en   = fire;
	assign wr_addr = col;
	assign wr_data = run_new;

	// copy of the last written run for forwarding
	always_ff @(posedge clk) begin
		if (fire) begin
			fwd_q <= run_new;
		end
	end

	// scan state; cleared on a register write and after each matrix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			across_q   <= 2'd0;
			hit_seen_q <= 1'b0;
			hit_row_q  <= '0;
			hit_col_q  <= '0;
		end else if (restart || (fire && ctl.last)) begin
			across_q   <= 2'd0;
			hit_seen_q <= 1'b0;
			hit_row_q  <= '0;
			hit_col_q  <= '0;
		end else if (fire) begin
			across_q   <= across_new;
			hit_seen_q <= hit_seen_n;
			hit_row_q  <= hit_row_n;
			hit_col_q  <= hit_col_n;
		end
	end

	// result word valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && ctl.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result word payload
	always_ff @(posedge clk) begin
		if (fire && ctl.last) begin
			found_q    <= hit_seen_n;
			top_row_q  <= hit_seen_n ? POS_W'(hit_row_n) : '0;
			left_col_q <= hit_seen_n ? POS_W'(hit_col_n) : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign top_row   = top_row_q;
	assign left_col  = left_col_q;

	// a final element never overwrites a result word still waiting
	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(fire && ctl.last && out_valid_q && !out_ready))
		else $error("result word overwritten before it was taken");

	// corner fields are zero when no window was found
	a_empty_corner: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && ctl.last && !hit_seen_n) |=> (top_row == '0 && left_col == '0))
		else $error("corner fields not cleared without a match");

	// a non-negative element always writes a zero run
	a_run_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !ctl.neg) |-> (wr_data == 2'd0))
		else $error("run count kept across a non-negative element");

endmodule

/* src/last_negative_window_finder.sv */
// last_negative_window_finder: top level. Position counters, dimension
// registers, first pipeline stage. Uses lnwf_pkg, lnwf_run_mem, lnwf_window_eval.
//
// Usage:
//  - Elements of a row_count x col_count matrix enter in row-major order on
//    the in_valid/in_ready channel, one word per element; only the sign of
//    sample matters. A dimension of 0 counts as 1, above MAX_DIM as MAX_DIM.
//  - After the final element of a matrix one result word leaves on the
//    out_valid/out_ready channel: found, and the top-left corner of the
//    last all-negative 3x3 window in scan order (both 0 when none).
//  - Throughput: one element per cycle unless stage 1 stalls. Each element
//    reads its column's run count from the line store in stage 0 and writes
//    it back in stage 1; a run written as it is read again is forwarded.
//  - Result: the final element is registered into stage 1, and the result
//    word is registered when that element leaves stage 1.
//  - Stall: a result word waiting on out_ready holds back only the next
//    final element, which waits in stage 1 while in_ready is low.
//  - Reset: dimensions return to 3x3 and the scan restarts at row 0,
//    column 0. The line store needs no clearing: row 0 ignores it.
//  - A write to either dimension register restarts the scan; write only
//    while the block is idle. Writes to other indexes are ignored.
module last_negative_window_finder #(
	parameter int MAX_DIM = 128
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [lnwf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lnwf_pkg::CFG_W-1:0]       cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [lnwf_pkg::SAMPLE_W-1:0] sample,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             found,
	output logic [lnwf_pkg::POS_W-1:0]       top_row,
	output logic [lnwf_pkg::POS_W-1:0]       left_col
);

	import lnwf_pkg::*;

	localparam int IDX_W = $clog2(MAX_DIM);
	localparam int CNT_W = $clog2(MAX_DIM + 1);

	logic [CFG_W-1:0] row_count_q;
	logic [CFG_W-1:0] col_count_q;
	logic [IDX_W-1:0] row_q;
	logic [IDX_W-1:0] col_q;
	lnwf_ctl_t        ctl_s1;
	lnwf_ctl_t        ctl_n;
	logic [IDX_W-1:0] row_s1;
	logic [IDX_W-1:0] col_s1;

	logic [CNT_W-1:0] rows_eff;
	logic [CNT_W-1:0] cols_eff;
	logic             row_last;
	logic             col_last;
	logic             s1_adv;
	logic             s1_fire;
	logic             in_acc;
	logic             restart;

	logic [1:0]       rd_data;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [1:0]       wr_data;

	// dimension registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= DIM_RESET;
			col_count_q <= DIM_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_ROW_COUNT: row_count_q <= cfg_data;
				REG_COL_COUNT: col_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign restart = cfg_wr_en && (cfg_index == REG_ROW_COUNT || cfg_index == REG_COL_COUNT);

	// dimensions in use: zero as one, clamp to MAX_DIM
	always_comb begin
		if (row_count_q == '0) begin
			rows_eff = CNT_W'(1);
		end else if (32'(row_count_q) > 32'(MAX_DIM)) begin
			rows_eff = CNT_W'(MAX_DIM);
		end else begin
			rows_eff = CNT_W'(row_count_q);
		end
		if (col_count_q == '0) begin
			cols_eff = CNT_W'(1);
		end else if (32'(col_count_q) > 32'(MAX_DIM)) begin
			cols_eff = CNT_W'(MAX_DIM);
		end else begin
			cols_eff = CNT_W'(col_count_q);
		end
	end

	assign row_last = (CNT_W'(row_q) + CNT_W'(1)) == rows_eff;
	assign col_last = (CNT_W'(col_q) + CNT_W'(1)) == cols_eff;

	// handshake: stage 1 stalls only with a final element behind a waiting result
	assign s1_adv   = !ctl_s1.valid || !ctl_s1.last || !out_valid || out_ready;
	assign s1_fire  = ctl_s1.valid && s1_adv;
	assign in_ready = s1_adv;
	assign in_acc   = in_valid && in_ready;

	// position of the next element
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (restart) begin
			row_q <= '0;
			col_q <= '0;
		end else if (in_acc) begin
			if (!col_last) begin
				col_q <= col_q + IDX_W'(1);
			end else begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + IDX_W'(1);
			end
		end
	end

	// control word for stage 1
	always_comb begin
		ctl_n.valid     = 1'b1;
		ctl_n.neg       = sample[SAMPLE_W-1];
		ctl_n.first_row = (row_q == '0);
		ctl_n.first_col = (col_q == '0);
		ctl_n.row_ge2   = (row_q >= IDX_W'(2));
		ctl_n.col_ge2   = (col_q >= IDX_W'(2));
		ctl_n.last      = row_last && col_last;
		ctl_n.fwd       = s1_fire && (col_s1 == col_q);
	end

	// stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (s1_adv) begin
			ctl_s1 <= in_acc ? ctl_n : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			row_s1 <= row_q;
			col_s1 <= col_q;
		end
	end

	lnwf_run_mem #(
		.DEPTH (MAX_DIM),
		.AW    (IDX_W)
	) u_run_mem (
		.clk     (clk),
		.rd_en   (in_acc),
		.rd_addr (col_q),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	lnwf_window_eval #(
		.IDX_W (IDX_W)
	) u_window_eval (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (restart),
		.fire      (s1_fire),
		.ctl       (ctl_s1),
		.row       (row_s1),
		.col       (col_s1),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.found     (found),
		.top_row   (top_row),
		.left_col  (left_col)
	);

	// input is held back only by a final element stuck in stage 1
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (ctl_s1.valid && ctl_s1.last && out_valid))
		else $error("input stalled without a waiting result");

	// forwarding only between consecutive elements of one column
	a_fwd_same_col: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && ctl_n.fwd) |=> (ctl_s1.fwd && col_s1 == $past(col_s1)))
		else $error("run forwarded across different columns");

endmodule
